@@ rtl/ssd_pkg.sv @@
// Shared types, constants and segment lookup for the seven-segment scan driver.
package ssd_pkg;

  localparam int unsigned ValueW  = 16;
  localparam int unsigned RepW    = 4;
  localparam int unsigned BcdW    = 16;
  localparam int unsigned BitCntW = $clog2(ValueW);

  localparam logic [ValueW-1:0] HundredsThreshold  = 16'd99;
  localparam logic [ValueW-1:0] ThousandsThreshold = 16'd999;
  localparam logic [7:0]        DpLitMask          = 8'h7F;
  localparam logic [7:0]        SegBlank           = 8'hFF;

  // Digit positions within a scan pass
  localparam logic [1:0] DIG_ONES      = 2'd0;
  localparam logic [1:0] DIG_TENS      = 2'd1;
  localparam logic [1:0] DIG_HUNDREDS  = 2'd2;
  localparam logic [1:0] DIG_THOUSANDS = 2'd3;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [RepW-1:0]   repeats;
  } in_t;

  typedef struct packed {
    logic [7:0] segment_byte;
    logic [3:0] digit_select;
    logic       last_frame;
  } out_t;

  // Request handed from the converter side to the frame sequencer
  typedef struct packed {
    logic              start;
    logic [BcdW-1:0]   bcd;
    logic [RepW-1:0]   repeats;
    logic              show_hund;
    logic              show_thou;
  } scan_req_t;

  // Common-anode, active-low pattern for one decimal digit
  function automatic logic [7:0] seg_lut(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

endpackage

@@ rtl/ssd_dabble.sv @@
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
module ssd_dabble (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ssd_pkg::ValueW-1:0] value,
  output logic                      done,
  output logic [ssd_pkg::BcdW-1:0]  bcd
);
  import ssd_pkg::*;

  logic [ValueW-1:0]  bin_r, bin_nxt;
  logic [BcdW-1:0]    bcd_r, bcd_nxt;
  logic [BitCntW-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [BcdW-1:0]    adj;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < BcdW / 4; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3 : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = value;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Drop the carry out of the top digit: keeps value mod 10000
      bcd_nxt = {adj[BcdW-2:0], bin_r[ValueW-1]};
      bin_nxt = {bin_r[ValueW-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == BitCntW'(ValueW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

@@ rtl/ssd_framer.sv @@
// Frame sequencer: walks digits and passes, one frame per cycle into an output register unless out_ready stalls.
module ssd_framer (
  input  logic               clk,
  input  logic               rst_n,
  input  ssd_pkg::scan_req_t req,
  output logic               idle,
  output logic               out_valid,
  input  logic               out_ready,
  output ssd_pkg::out_t      out_data
);
  import ssd_pkg::*;

  logic              busy_r, busy_nxt;
  logic [1:0]        digit_r, digit_nxt;
  logic [RepW-1:0]   pass_r, pass_nxt;
  logic [BcdW-1:0]   bcd_r;
  logic [RepW-1:0]   rep_r;
  logic              hund_r, thou_r;
  logic              ov_r, ov_nxt;
  out_t              od_r, od_nxt;
  logic [1:0]        max_digit;
  logic              load;
  logic              last;
  logic [3:0]        nib;
  logic [7:0]        seg;

  always_comb begin
    if (thou_r)      max_digit = DIG_THOUSANDS;
    else if (hund_r) max_digit = DIG_HUNDREDS;
    else             max_digit = DIG_TENS;
  end

  assign load = busy_r && (!ov_r || out_ready);
  assign last = (pass_r == rep_r) && (digit_r == max_digit);

  always_comb begin
    case (digit_r)
      DIG_ONES:     nib = bcd_r[3:0];
      DIG_TENS:     nib = bcd_r[7:4];
      DIG_HUNDREDS: nib = bcd_r[11:8];
      default:      nib = bcd_r[15:12];
    endcase
    seg = seg_lut(nib);
    if (digit_r == DIG_TENS) seg = seg & DpLitMask;
  end

  always_comb begin
    busy_nxt  = busy_r;
    digit_nxt = digit_r;
    pass_nxt  = pass_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (load) begin
      ov_nxt              = 1'b1;
      od_nxt.segment_byte = seg;
      od_nxt.digit_select = 4'b0001 << digit_r;
      od_nxt.last_frame   = last;
      if (last) begin
        busy_nxt = 1'b0;
      end else if (digit_r == max_digit) begin
        digit_nxt = DIG_ONES;
        pass_nxt  = pass_r + 1'b1;
      end else begin
        digit_nxt = digit_r + 1'b1;
      end
    end
    if (req.start) begin
      busy_nxt  = 1'b1;
      digit_nxt = DIG_ONES;
      pass_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      ov_r    <= 1'b0;
      digit_r <= DIG_ONES;
      pass_r  <= '0;
    end else begin
      busy_r  <= busy_nxt;
      ov_r    <= ov_nxt;
      digit_r <= digit_nxt;
      pass_r  <= pass_nxt;
    end
    od_r <= od_nxt;
    if (req.start) begin
      bcd_r  <= req.bcd;
      rep_r  <= req.repeats;
      hund_r <= req.show_hund;
      thou_r <= req.show_thou;
    end
  end

  assign idle      = !busy_r && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

@@ rtl/seven_segment_scan_driver.sv @@
// Top level of the four-digit seven-segment scan driver.
// Path: an accepted request runs through the bit-serial BCD conversion, is handed to the
//   frame sequencer, and each frame is loaded into the output register.
// Throughput: one frame per cycle once scanning, unless out_ready stalls the output; a new
//   request is accepted only after the last frame has left (frames = 2..4 per pass times
//   repeats+1, at most 64).
// Reset: synchronous active-low rst_n returns to idle and drops all pending frames.
module seven_segment_scan_driver (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ssd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ssd_pkg::out_t out_data
);
  import ssd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [RepW-1:0] rep_r;
  logic            hund_r, thou_r;
  logic            in_acc;
  logic            conv_done;
  logic [BcdW-1:0] conv_bcd;
  logic            fr_idle;
  scan_req_t       req;

  // Take a request only when nothing is in flight
  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Hold the pass count and digit-enable flags; thresholds use the full value
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rep_r  <= in_data.repeats;
      hund_r <= in_data.value > HundredsThreshold;
      thou_r <= in_data.value > ThousandsThreshold;
    end
  end

  ssd_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .value (in_data.value),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // Launch scanning the cycle the digits are ready
  always_comb begin
    req.start     = conv_done;
    req.bcd       = conv_bcd;
    req.repeats   = rep_r;
    req.show_hund = hund_r;
    req.show_thou = thou_r;
  end

  ssd_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .idle      (fr_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Advance: idle -> convert -> scan -> idle once the last frame has left
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_CONV;
      ST_CONV: if (conv_done) state_nxt = ST_SCAN;
      ST_SCAN: if (fr_idle) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_out_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_SCAN)
    else $error("frame valid outside scan phase");

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_CONV && !out_valid)
    else $error("accepted request did not start conversion");

  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> state_r == ST_CONV)
    else $error("conversion finished outside conversion phase");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_frame |=> !out_valid)
    else $error("frame emitted after last frame");

endmodule

@@ dv/tb_seven_segment_scan_driver.sv @@
// Self-checking testbench for the four-digit seven-segment scan driver.
`timescale 1ns / 100ps

module tb_seven_segment_scan_driver;
  import ssd_pkg::*;

  // Common-anode patterns for digits 0..9, active low
  localparam logic [7:0] SEG_PATTERN [0:9] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };
  localparam logic [7:0] DP_CLEAR = 8'h7F;

  // One-hot digit enables, derived from the digit positions
  localparam logic [3:0] SEL_ONES      = 4'd1 << DIG_ONES;
  localparam logic [3:0] SEL_TENS      = 4'd1 << DIG_TENS;
  localparam logic [3:0] SEL_HUNDREDS  = 4'd1 << DIG_HUNDREDS;
  localparam logic [3:0] SEL_THOUSANDS = 4'd1 << DIG_THOUSANDS;

  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RANDOM_REQS  = 480;
  localparam int unsigned TAIL_CYCLES  = 40;   // settle time after the last frame
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned MAX_REPORTS  = 10;

  // Pending request plus a flag that holds it back until all earlier frames have been checked
  typedef struct {
    in_t req;
    bit  drain_first;
  } stim_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;

  stim_t       pending_reqs[$];
  out_t        frames_due[$];
  int unsigned total_reqs;
  int unsigned directed_reqs;
  int unsigned reqs_accepted = 0;
  int unsigned frames_checked = 0;
  int unsigned mismatches = 0;
  int unsigned drain_pauses = 0;
  int unsigned wrap_cases = 0;    // values 10000..10099
  int unsigned max_frames = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_idle_pct = 29;
  int unsigned rx_idle_pct = 88;

  seven_segment_scan_driver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expand one request into its scan frames, last one marked.
  function automatic void queue_scan_frames(input in_t req);
    int unsigned v;
    int unsigned per_pass;
    int unsigned total;
    int unsigned k;
    logic [7:0]  seg_ones, seg_tens, seg_hund, seg_thou;
    out_t        f;
    v = req.value;
    seg_ones = SEG_PATTERN[v % 10];
    seg_tens = SEG_PATTERN[(v % 100) / 10] & DP_CLEAR;
    seg_hund = SEG_PATTERN[(v % 1000) / 100];
    seg_thou = SEG_PATTERN[(v % 10000) / 1000];
    per_pass = 2 + ((v > 99) ? 1 : 0) + ((v > 999) ? 1 : 0);
    total = per_pass * (req.repeats + 1);
    if (total > max_frames) max_frames = total;
    k = 0;
    for (int p = 0; p <= int'(req.repeats); p++) begin
      f.segment_byte = seg_ones;
      f.digit_select = SEL_ONES;
      f.last_frame   = (k == total - 1);
      frames_due.push_back(f);
      k++;
      f.segment_byte = seg_tens;
      f.digit_select = SEL_TENS;
      f.last_frame   = (k == total - 1);
      frames_due.push_back(f);
      k++;
      // Hundreds and thousands gate on the full value, not the wrapped one
      if (v > 99) begin
        f.segment_byte = seg_hund;
        f.digit_select = SEL_HUNDREDS;
        f.last_frame   = (k == total - 1);
        frames_due.push_back(f);
        k++;
      end
      if (v > 999) begin
        f.segment_byte = seg_thou;
        f.digit_select = SEL_THOUSANDS;
        f.last_frame   = (k == total - 1);
        frames_due.push_back(f);
        k++;
      end
    end
  endfunction

  task automatic add_request(input int unsigned value, input int unsigned repeats,
                             input bit drain_first);
    stim_t s;
    s.req.value   = value[15:0];
    s.req.repeats = repeats[3:0];
    s.drain_first = drain_first;
    pending_reqs.push_back(s);
  endtask

  // Random value: weight the ranges that change the frame count or wrap
  function automatic int unsigned pick_value();
    int unsigned v;
    case ($urandom_range(7))
      0:       v = $urandom_range(99);
      1:       v = $urandom_range(999, 100);
      2:       v = $urandom_range(9999, 1000);
      3:       v = $urandom_range(10099, 10000);
      4:       v = $urandom_range(65535, 10100);
      default: v = $urandom_range(65535);
    endcase
    return v;
  endfunction

  // Driver: present the next request when the slot is free; record accepted ones.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        queue_scan_frames(in_data);
        if (in_data.value >= 10000 && in_data.value <= 10099) wrap_cases++;
        reqs_accepted++;
        // Swap the stall profile by thirds of the run, then drop idling
        if (reqs_accepted >= (2 * total_reqs) / 3) begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end else if (reqs_accepted >= total_reqs / 3) begin
          tx_idle_pct = 88;
          rx_idle_pct = 29;
        end
      end
      // The slot frees up once the current request is taken or none is shown
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 &&
            !(pending_reqs[0].drain_first && frames_due.size() > 0) &&
            $urandom_range(99) >= tx_idle_pct) begin
          if (pending_reqs[0].drain_first) drain_pauses++;
          in_data  <= pending_reqs[0].req;
          in_valid <= 1'b1;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted frame against the oldest expected one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected frame: seg=%02h sel=%01h last=%0b",
                     out_data.segment_byte, out_data.digit_select, out_data.last_frame);
        end else begin
          if (out_data.segment_byte !== frames_due[0].segment_byte ||
              out_data.digit_select !== frames_due[0].digit_select ||
              out_data.last_frame   !== frames_due[0].last_frame) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"frame %0d mismatch: seg exp %02h got %02h, ",
                        "sel exp %01h got %01h, last exp %0b got %0b"},
                       frames_checked,
                       frames_due[0].segment_byte, out_data.segment_byte,
                       frames_due[0].digit_select, out_data.digit_select,
                       frames_due[0].last_frame, out_data.last_frame);
          end
          void'(frames_due.pop_front());
        end
        frames_checked++;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", quiet_cycles);
        $display("tb_seven_segment_scan_driver NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // Directed: digit-count boundaries, wrap past 9999, repeat extremes
    add_request(0, 0, 1'b0);
    add_request(9, 0, 1'b0);
    add_request(10, 0, 1'b0);
    add_request(99, 0, 1'b0);
    add_request(100, 0, 1'b0);
    add_request(999, 0, 1'b0);
    add_request(1000, 0, 1'b0);
    add_request(1234, 1, 1'b0);
    add_request(5678, 2, 1'b0);
    add_request(9999, 0, 1'b0);
    add_request(10000, 0, 1'b0);
    add_request(10099, 1, 1'b0);
    add_request(10100, 0, 1'b0);
    add_request(65535, 15, 1'b0);
    add_request(0, 15, 1'b0);
    add_request(9999, 15, 1'b0);
    add_request(50, 15, 1'b0);
    add_request(43210, 3, 1'b1);    // hold until the pipe is empty
    add_request(32768, 8, 1'b0);
    add_request(21845, 5, 1'b0);
    add_request(43690, 10, 1'b0);
    directed_reqs = pending_reqs.size();

    // Random: mostly short repeat counts, occasionally up to the maximum
    for (int i = 0; i < RANDOM_REQS; i++) begin
      add_request(pick_value(),
                  ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3),
                  ($urandom_range(49) == 0) || (i == 100) || (i == 300));
    end
    total_reqs = pending_reqs.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all requests in, all frames out, then let the pipe settle
    while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
    while (frames_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d directed, %0d wrapped past 9999), %0d frames checked",
             reqs_accepted, directed_reqs, wrap_cases, frames_checked);
    $display("longest request %0d frames, %0d drain pauses, three stall profiles",
             max_frames, drain_pauses);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("tb_seven_segment_scan_driver OK");
    end else begin
      $display("%0d mismatches, %0d frames outstanding", mismatches, frames_due.size());
      $display("tb_seven_segment_scan_driver NOT OK");
    end
    $finish;
  end

endmodule
